>>> rtl/sorted_sleep_wake_queue_unit_macros.svh
// Assertion macros for the sorted sleep/wake queue unit.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef SORTED_SLEEP_WAKE_QUEUE_UNIT_MACROS_SVH
`define SORTED_SLEEP_WAKE_QUEUE_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SSW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define SSW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ssw_pkg.sv
// Shared types and constants for the sorted sleep/wake queue unit.
// No dependencies.
`timescale 1ns / 1ps

package ssw_pkg;

   localparam int TIME_W      = 63;
   localparam int ID_W        = 8;
   localparam int LEN_W       = 32;
   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_SLEEP = 1'b1;

   localparam logic ST_WOKEN   = 1'b0;
   localparam logic ST_REFUSED = 1'b1;

   // One sleeper entry of the table.
   typedef struct packed {
      logic [TIME_W-1:0] wake;
      logic [ID_W-1:0]   id;
   } entry_type;

   // Result of the shared magnitude comparator.
   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;

endpackage

>>> rtl/sorted_sleep_wake_queue_unit.sv
// Sorted sleep/wake queue: tick counter plus a ring table of sleepers ordered by wake time.
// A tick wakes due threads at the head; a sleep shifts each entry waking no earlier up one
// place from the tail; a full table refuses a sleep; a zero-length sleep has no effect. One
// table read port and one shared comparator serve both walks; ticks and refusals can stall
// on rsp_ready; one transaction is in work at a time. Synchronous active-high reset empties
// the table and zeroes the counter. Depends on ssw_pkg, ssw_cmp and the macros header.
`timescale 1ns / 1ps
`include "sorted_sleep_wake_queue_unit_macros.svh"

module sorted_sleep_wake_queue_unit
   import ssw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [ID_W-1:0]   req_thread_id,
   input  logic [LEN_W-1:0]  req_sleep_ticks,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ID_W-1:0]   rsp_woken_id,
   output logic              rsp_status,
   output logic [TIME_W-1:0] rsp_now_ticks,
   output logic              rsp_last
);

   // Table addresses and the occupancy count. The occupancy needs one extra code
   // so that it can hold the full depth.
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_OCC  = CW'(QUEUE_DEPTH);
   localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);
   localparam logic [NRES_W-1:0] NRES_MAX = NRES_W'(MAX_RESULTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_TICK,
      ST_REFUSE
   } state_type;

   // The table is a ring: logical entry 0 (earliest wake time) sits at head_ff.
   entry_type table_mem [QUEUE_DEPTH];

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [TIME_W-1:0] count_ff, count_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   logic              have_pend_ff, have_pend_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [TIME_W-1:0] wt_ff, wt_in;
   logic [AW-1:0]     jptr_ff, jptr_in;
   logic [CW-1:0]     jleft_ff, jleft_in;
   entry_type         rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [TIME_W-1:0] rsp_now_ff, rsp_now_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;
   logic [AW-1:0]     rd_addr;

   logic [SW-1:0]     tail_sum;
   logic [AW-1:0]     tail;
   logic [AW-1:0]     tail_prev;
   logic [AW-1:0]     head_next;
   logic [AW-1:0]     jptr_prev;
   logic [AW-1:0]     jptr_prev2;
   logic [TIME_W-1:0] cmp_key;
   cmp_type           cmp_res;
   logic              slot_free;
   logic              due;
   logic              stop;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
      ring_inc = (p == LAST_ADDR) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
      ring_dec = (p == '0) ? LAST_ADDR : p - AW'(1);
   endfunction

   // Ring position just past the youngest entry. The table is never full when
   // this is used for a write, so one conditional subtract brings it into range.
   assign tail_sum   = SW'(head_ff) + SW'(occ_ff);
   assign tail       = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
   assign tail_prev  = ring_dec(tail);
   assign head_next  = ring_inc(head_ff);
   assign jptr_prev  = ring_dec(jptr_ff);
   assign jptr_prev2 = ring_dec(jptr_prev);

   // One comparator serves both walks: during an insert it checks an entry against the
   // new wake time, during a tick it checks the head entry against the counter.
   assign cmp_key = (state_ff == ST_INSERT) ? wt_ff : count_ff;

   ssw_cmp u_cmp (
      .lhs (rd_data_ff.wake),
      .rhs (cmp_key),
      .res (cmp_res)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign due  = (occ_ff != '0) && (nres_ff < NRES_MAX) && (cmp_res.lt || cmp_res.eq);
   assign stop = (jleft_ff == '0) || cmp_res.lt;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      count_in      = count_ff;
      nres_in       = nres_ff;
      have_pend_in  = have_pend_ff;
      pend_id_in    = pend_id_ff;
      wt_in         = wt_ff;
      jptr_in       = jptr_ff;
      jleft_in      = jleft_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = jptr_ff;
      wr_data       = rd_data_ff;
      rd_addr       = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_action == ACT_TICK) ? head_ff : tail_prev;
            if (req_valid) begin
               if (req_action == ACT_TICK) begin
                  count_in     = count_ff + TIME_W'(1);
                  nres_in      = '0;
                  have_pend_in = 1'b0;
                  state_in     = ST_TICK;
               end else if (req_sleep_ticks != '0) begin
                  if (occ_ff == FULL_OCC) begin
                     pend_id_in = req_thread_id;
                     state_in   = ST_REFUSE;
                  end else begin
                     wt_in      = count_ff + TIME_W'(req_sleep_ticks);
                     pend_id_in = req_thread_id;
                     jptr_in    = tail;
                     jleft_in   = occ_ff;
                     state_in   = ST_INSERT;
                  end
               end
            end
         end

         // Insertion walk from the tail: each entry that wakes at or after the new
         // one moves up by one place; the new entry lands just above the first earlier one.
         ST_INSERT: begin
            wr_en   = 1'b1;
            rd_addr = jptr_prev2;
            if (stop) begin
               wr_data.wake = wt_ff;
               wr_data.id   = pend_id_ff;
               occ_in       = occ_ff + CW'(1);
               state_in     = ST_IDLE;
            end else begin
               jptr_in  = jptr_prev;
               jleft_in = jleft_ff - CW'(1);
            end
         end

         // Wake walk from the head. A popped entry is held until the next head has been
         // checked, so that the result knows whether it is the last of this tick.
         ST_TICK: begin
            if (have_pend_ff) begin
               if (slot_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = pend_id_ff;
                  rsp_status_in = ST_WOKEN;
                  rsp_now_in    = count_ff;
                  rsp_last_in   = !due;
                  if (due) begin
                     pend_id_in = rd_data_ff.id;
                     head_in    = head_next;
                     occ_in     = occ_ff - CW'(1);
                     nres_in    = nres_ff + NRES_W'(1);
                     rd_addr    = head_next;
                  end else begin
                     have_pend_in = 1'b0;
                     state_in     = ST_IDLE;
                  end
               end
            end else if (due) begin
               pend_id_in   = rd_data_ff.id;
               have_pend_in = 1'b1;
               head_in      = head_next;
               occ_in       = occ_ff - CW'(1);
               nres_in      = nres_ff + NRES_W'(1);
               rd_addr      = head_next;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_REFUSE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = pend_id_ff;
               rsp_status_in = ST_REFUSED;
               rsp_now_in    = count_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         count_ff     <= '0;
         nres_ff      <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         nres_ff      <= nres_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_id_ff    <= pend_id_in;
      wt_ff         <= wt_in;
      jptr_ff       <= jptr_in;
      jleft_ff      <= jleft_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Table storage: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_woken_id  = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_now_ticks = rsp_now_ff;
   assign rsp_last      = rsp_last_ff;

   `SSW_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= FULL_OCC, "occupancy beyond depth")
   `SSW_ASSERT_ALWAYS(a_nres_bound, clock, reset, nres_ff <= NRES_MAX, "too many wakes per tick")
   `SSW_ASSERT_NEXT(a_tick_count, clock, reset, req_valid && req_ready && req_action == ACT_TICK, count_ff == $past(count_ff) + TIME_W'(1), "tick did not advance the counter")
   `SSW_ASSERT_SAME(a_refuse_last, clock, reset, rsp_valid && rsp_status == ST_REFUSED, rsp_last, "refusal not marked last")

endmodule

>>> rtl/ssw_cmp.sv
// Shared 63-bit unsigned magnitude comparator of the sleep/wake queue.
// Depends on ssw_pkg.
`timescale 1ns / 1ps

module ssw_cmp
   import ssw_pkg::*;
(
   input  logic [TIME_W-1:0] lhs,
   input  logic [TIME_W-1:0] rhs,
   output cmp_type           res
);

   always_comb begin
      res.lt = (lhs < rhs);
      res.eq = (lhs == rhs);
   end

endmodule
